// ===== rtl/core/spmd_pkg.sv =====
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types, widths, register codes and the microstep sine table for the
// closed-loop stepper microstep driver.
// ----------------------------------------------------------------------------
package spmd_pkg;

    // Microsteps in one electrical cycle and the widths that follow from it.
    localparam int MICROSTEPS = 16;
    localparam int PHASE_W    = $clog2(MICROSTEPS);
    localparam int SLACK_W    = PHASE_W + 2;
    localparam int QTR_STEPS  = MICROSTEPS / 4;

    // Field widths.
    localparam int ANGLE_W    = 15;
    localparam int EFFORT_W   = 12;
    localparam int DBAND_W    = 12;
    localparam int LEVEL_W    = 12;
    localparam int DIR_W      = 2;
    localparam int MAG_W      = 11;
    localparam int AMPL_SHIFT = 10;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index taken from the word address.
    localparam logic REG_EFFORT   = 1'b0;
    localparam logic REG_DEADBAND = 1'b1;

    localparam logic [EFFORT_W-1:0] EFFORT_RESET = 12'd2048;
    localparam logic [DBAND_W-1:0]  DBAND_RESET  = 12'd91;

    // H-bridge direction codes.
    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    // Sine magnitude at each microstep phase, amplitude 1024, and the sign.
    localparam logic [MAG_W-1:0] SINE_MAG [MICROSTEPS] = '{
        11'd0,    11'd392,  11'd724,  11'd946,
        11'd1024, 11'd946,  11'd724,  11'd392,
        11'd0,    11'd392,  11'd724,  11'd946,
        11'd1024, 11'd946,  11'd724,  11'd392
    };
    localparam logic [MICROSTEPS-1:0] SINE_NEG = 16'hFE00;

    typedef struct packed {
        logic [ANGLE_W-1:0] measured_angle;
        logic [ANGLE_W-1:0] target_angle;
        logic               target_valid;
        logic               fault;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] coil_a_level;
        logic [DIR_W-1:0]   coil_a_dir;
        logic [LEVEL_W-1:0] coil_b_level;
        logic [DIR_W-1:0]   coil_b_dir;
        logic               driving;
    } t_out_item;

    typedef struct packed {
        logic               drive;
        logic [PHASE_W-1:0] phase;
    } t_step;

endpackage

// ===== rtl/core/spmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmd_ctrl
// Position compare, slack counter and microstep phase register.
// ----------------------------------------------------------------------------
module spmd_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  spmd_pkg::t_in_item                  i_item,
    input  logic [spmd_pkg::DBAND_W-1:0]        i_deadband,
    output spmd_pkg::t_step                     o_step
);

    localparam logic signed [spmd_pkg::SLACK_W-1:0] SLACK_FULL =
        spmd_pkg::SLACK_W'(spmd_pkg::MICROSTEPS);
    localparam logic signed [spmd_pkg::SLACK_W-1:0] SLACK_ONE =
        spmd_pkg::SLACK_W'(1);
    localparam logic [spmd_pkg::PHASE_W-1:0] PHASE_LAST =
        spmd_pkg::PHASE_W'(spmd_pkg::MICROSTEPS - 1);

    logic [spmd_pkg::PHASE_W-1:0]        r_phase, n_phase;
    logic signed [spmd_pkg::SLACK_W-1:0] r_slack, n_slack;
    logic [spmd_pkg::ANGLE_W:0]          meas_x, targ_x, db_x;
    logic                                over, under, move_up, move_dn;

    assign meas_x = {1'b0, i_item.measured_angle};
    assign targ_x = {1'b0, i_item.target_angle};
    assign db_x   = (spmd_pkg::ANGLE_W + 1)'(i_deadband);
    assign over   = meas_x > (targ_x + db_x);
    assign under  = (meas_x + db_x) < targ_x;

    always_comb begin
        move_up = 1'b0;
        move_dn = 1'b0;
        n_slack = r_slack;
        if (i_item.fault || !i_item.target_valid) begin
            n_slack = r_slack;
        end else if (over) begin
            move_up = 1'b1;
            n_slack = SLACK_FULL;
        end else if (under) begin
            move_dn = 1'b1;
            n_slack = -SLACK_FULL;
        end else if (r_slack > 0) begin
            move_up = 1'b1;
            n_slack = r_slack - SLACK_ONE;
        end else if (r_slack < 0) begin
            move_dn = 1'b1;
            n_slack = r_slack + SLACK_ONE;
        end

        n_phase = r_phase;
        if (move_up) begin
            n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;
        end else if (move_dn) begin
            n_phase = (r_phase == '0) ? PHASE_LAST : r_phase - 1'b1;
        end
    end

    assign o_step.drive = move_up || move_dn;
    assign o_step.phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_slack <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_slack <= n_slack;
        end
    end

`ifndef SYNTHESIS
    a_slack_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slack <= SLACK_FULL) && (r_slack >= -SLACK_FULL))
        else $error("slack counter left its range");

    a_hold_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.fault || !i_item.target_valid)
        |=> $stable(r_phase) && $stable(r_slack))
        else $error("phase or slack moved on a fault or invalid target");
`endif

endmodule

// ===== rtl/core/spmd_coil.sv =====
// ----------------------------------------------------------------------------
// spmd_coil
// Sine lookup and effort scaling for one coil, as magnitude plus direction.
// ----------------------------------------------------------------------------
module spmd_coil (
    input  logic                                i_drive,
    input  logic [spmd_pkg::PHASE_W-1:0]        i_phase,
    input  logic [spmd_pkg::EFFORT_W-1:0]       i_effort,
    output logic [spmd_pkg::LEVEL_W-1:0]        o_level,
    output logic [spmd_pkg::DIR_W-1:0]          o_dir
);

    localparam int PROD_W = spmd_pkg::EFFORT_W + spmd_pkg::MAG_W;

    logic [spmd_pkg::MAG_W-1:0] mag;
    logic                       neg;
    logic [PROD_W-1:0]          prod;

    assign mag  = spmd_pkg::SINE_MAG[i_phase];
    assign neg  = spmd_pkg::SINE_NEG[i_phase];
    assign prod = PROD_W'(i_effort) * PROD_W'(mag);

    // The product over 1024 never exceeds the level width.
    always_comb begin
        if (i_drive) begin
            o_level = prod[spmd_pkg::AMPL_SHIFT +: spmd_pkg::LEVEL_W];
            o_dir   = neg ? spmd_pkg::DIR_REV : spmd_pkg::DIR_FWD;
        end else begin
            o_level = '0;
            o_dir   = spmd_pkg::DIR_OFF;
        end
    end

endmodule

// ===== rtl/core/stepper_position_microstep_driver.sv =====
// ----------------------------------------------------------------------------
// stepper_position_microstep_driver
// Closed-loop microstep drive: one request per control tick in, one set of
// coil levels and bridge directions out.
// ----------------------------------------------------------------------------
// Each request carries the measured and target shaft angles in 15-bit sensor
// counts plus a target-valid and a fault flag, and produces exactly one result.
// The block takes a new request in every clock cycle while o_in_stall is low.
// A request is held in the input register, then the position compare, slack
// counter, phase step, sine lookup and effort multiply run in a single pass
// into the result register. A stall on the output fills both registers and
// then stalls the input. The sine table is constant logic, so there is no
// start-up sweep after reset. Motor effort sits at address 0 and the deadband
// at address 4; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module stepper_position_microstep_driver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  spmd_pkg::t_in_item                  i_in_item,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output spmd_pkg::t_out_item                 o_out_item,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spmd_pkg::ADDR_W-1:0]         paddr,
    input  logic [spmd_pkg::DATA_W-1:0]         pwdata,
    output logic [spmd_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    logic [spmd_pkg::EFFORT_W-1:0] r_effort;
    logic [spmd_pkg::DBAND_W-1:0]  r_deadband;
    logic                          r_in_vld, n_in_vld;
    logic                          r_out_vld, n_out_vld;
    spmd_pkg::t_in_item            r_in_item;
    spmd_pkg::t_out_item           r_out_item, n_out_item;
    spmd_pkg::t_step               step;
    logic [spmd_pkg::PHASE_W-1:0]  phase_b;
    logic                          out_free, fire, in_acc, cfg_wr;

    // ------------------------------------------------------------------
    // Configuration registers. The word address picks the register.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effort   <= spmd_pkg::EFFORT_RESET;
            r_deadband <= spmd_pkg::DBAND_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                spmd_pkg::REG_EFFORT:   r_effort   <= pwdata[spmd_pkg::EFFORT_W-1:0];
                spmd_pkg::REG_DEADBAND: r_deadband <= pwdata[spmd_pkg::DBAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            spmd_pkg::REG_EFFORT:   prdata = spmd_pkg::DATA_W'(r_effort);
            spmd_pkg::REG_DEADBAND: prdata = spmd_pkg::DATA_W'(r_deadband);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. The result register moves on when it is empty or its
    // content is taken; the input register then hands its request over.
    // ------------------------------------------------------------------
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (fire) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    // ------------------------------------------------------------------
    // Single-pass datapath: decide the step, then look up both coils.
    // Coil B runs a quarter electrical turn ahead of coil A.
    // ------------------------------------------------------------------
    spmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_in_item),
        .i_deadband (r_deadband),
        .o_step     (step)
    );

    always_comb begin
        if (step.phase >= spmd_pkg::PHASE_W'(spmd_pkg::MICROSTEPS - spmd_pkg::QTR_STEPS)) begin
            phase_b = step.phase - spmd_pkg::PHASE_W'(spmd_pkg::MICROSTEPS - spmd_pkg::QTR_STEPS);
        end else begin
            phase_b = step.phase + spmd_pkg::PHASE_W'(spmd_pkg::QTR_STEPS);
        end
    end

    spmd_coil u_coil_a (
        .i_drive  (step.drive),
        .i_phase  (step.phase),
        .i_effort (r_effort),
        .o_level  (n_out_item.coil_a_level),
        .o_dir    (n_out_item.coil_a_dir)
    );

    spmd_coil u_coil_b (
        .i_drive  (step.drive),
        .i_phase  (phase_b),
        .i_effort (r_effort),
        .o_level  (n_out_item.coil_b_level),
        .o_dir    (n_out_item.coil_b_dir)
    );

    assign n_out_item.driving = step.drive;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_off_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.driving
        |-> (o_out_item.coil_a_level == '0) && (o_out_item.coil_b_level == '0)
            && (o_out_item.coil_a_dir == spmd_pkg::DIR_OFF)
            && (o_out_item.coil_b_dir == spmd_pkg::DIR_OFF))
        else $error("coils not off on an idle result");

    a_drive_has_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.driving
        |-> (o_out_item.coil_a_dir != spmd_pkg::DIR_OFF)
            && (o_out_item.coil_b_dir != spmd_pkg::DIR_OFF))
        else $error("driving result without a bridge direction");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld && r_out_vld && i_out_stall)
        else $error("input stalled while the pipeline has room");
`endif

endmodule
